### rtl/core/fprlw_pkg.sv
// shared constants, command codes and the command word type of the page log writer
package fprlw_pkg;

  localparam int PAGE_SIZE = 256;
  localparam int NUM_PAGES = 4096;

  localparam int PageW   = 12;
  localparam int OfsW    = 10;
  localparam int LenW    = 11;
  localparam int SrcW    = 8;
  localparam int CountW  = 8;
  localparam int QDepth  = 4;
  localparam int QCntW   = 3;

  typedef enum logic [1:0] {
    CMD_BUF_WRITE = 2'd0,
    CMD_STORE     = 2'd1,
    CMD_META      = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic              buf_sel;
    logic [PageW-1:0]  page;
    logic [OfsW-1:0]   ofs;
    logic [LenW-1:0]   len;
    logic [SrcW-1:0]   src;
    logic [PageW-1:0]  read_page;
    logic              last;
  } cmd_t;

  // next page of the ring, pages 1 .. NUM_PAGES-1
  function automatic logic [PageW-1:0] advance_page(input logic [PageW-1:0] p);
    logic [PageW:0] s;
    s = {1'b0, p} + {{PageW{1'b0}}, 1'b1};
    if (s >= (PageW+1)'(NUM_PAGES)) begin
      return {{(PageW-1){1'b0}}, 1'b1};
    end
    return s[PageW-1:0];
  endfunction

endpackage

### rtl/core/flash_page_ring_log_writer.sv
// Circular flash page log writer: one request in, one, three or four flash commands out.
// Each accepted request is turned at acceptance into its whole command list (buffer write;
// or fill, store, page-0 metadata write and optional remainder write), which goes into a
// four-entry command queue. The queue head drives the single result port, one command per
// cycle while out_stall_i is low. The next request is taken in the same cycle in which the
// final command of the current one is taken, so with a request waiting the result port
// stays busy without gaps. Page pointers, fill offset and the active buffer are updated
// at acceptance; reset places the write and read pages at 1, the offset at 0 and buffer zero
// active.
module flash_page_ring_log_writer
  import fprlw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CountW-1:0] byte_count_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        cmd_kind_o,
  output logic              buffer_sel_o,
  output logic [PageW-1:0]  page_addr_o,
  output logic [OfsW-1:0]   byte_offset_o,
  output logic [LenW-1:0]   chunk_len_o,
  output logic [SrcW-1:0]   src_start_o,
  output logic [PageW-1:0]  read_page_o,
  output logic              last_o
);

  logic [PageW-1:0] write_page_q, write_page_d;
  logic [PageW-1:0] read_page_q, read_page_d;
  logic [OfsW-1:0]  fill_offset_q, fill_offset_d;
  logic             active_buf_q, active_buf_d;

  cmd_t             cmd_q [QDepth];
  cmd_t             cmd_d [QDepth];
  logic [QCntW-1:0] cnt_q, cnt_d;

  logic             take, last_take, accept;
  logic [LenW-1:0]  avail;
  logic             fits;
  logic [SrcW-1:0]  rest;
  logic [LenW-1:0]  sum;
  logic [PageW-1:0] wp_next, rp_next;
  logic [QCntW-1:0] new_cnt;

  assign take      = (cnt_q != '0) && !out_stall_i;
  assign last_take = take && (cnt_q == QCntW'(1));
  assign in_stall_o = (cnt_q != '0) && !last_take;
  assign accept    = in_valid_i && !in_stall_o;

  always_comb begin
    if ({1'b0, fill_offset_q} >= LenW'(PAGE_SIZE)) begin
      avail = '0;
    end else begin
      avail = LenW'(PAGE_SIZE) - {1'b0, fill_offset_q};
    end
    fits    = {{(LenW-CountW){1'b0}}, byte_count_i} < avail;
    // only meaningful when the request does not fit, then avail is at most byte_count
    rest    = byte_count_i - avail[SrcW-1:0];
    sum     = {1'b0, fill_offset_q} + {{(LenW-CountW){1'b0}}, byte_count_i};
    wp_next = advance_page(write_page_q);
    rp_next = (read_page_q == wp_next) ? advance_page(read_page_q) : read_page_q;
    if (fits) begin
      new_cnt = QCntW'(1);
    end else if (rest != '0) begin
      new_cnt = QCntW'(4);
    end else begin
      new_cnt = QCntW'(3);
    end
  end

  always_comb begin
    write_page_d  = write_page_q;
    read_page_d   = read_page_q;
    fill_offset_d = fill_offset_q;
    active_buf_d  = active_buf_q;
    cnt_d         = cnt_q;
    for (int i = 0; i < QDepth; i++) begin
      cmd_d[i] = cmd_q[i];
    end

    if (accept) begin
      cnt_d = new_cnt;

      cmd_d[0].kind      = CMD_BUF_WRITE;
      cmd_d[0].buf_sel   = active_buf_q;
      cmd_d[0].page      = write_page_q;
      cmd_d[0].ofs       = fill_offset_q;
      cmd_d[0].len       = fits ? {{(LenW-CountW){1'b0}}, byte_count_i} : avail;
      cmd_d[0].src       = '0;
      cmd_d[0].read_page = read_page_q;
      cmd_d[0].last      = fits;

      cmd_d[1].kind      = CMD_STORE;
      cmd_d[1].buf_sel   = active_buf_q;
      cmd_d[1].page      = write_page_q;
      cmd_d[1].ofs       = '0;
      cmd_d[1].len       = '0;
      cmd_d[1].src       = '0;
      cmd_d[1].read_page = read_page_q;
      cmd_d[1].last      = 1'b0;

      // metadata goes through the other buffer, which then becomes active
      cmd_d[2].kind      = CMD_META;
      cmd_d[2].buf_sel   = ~active_buf_q;
      cmd_d[2].page      = '0;
      cmd_d[2].ofs       = '0;
      cmd_d[2].len       = '0;
      cmd_d[2].src       = '0;
      cmd_d[2].read_page = rp_next;
      cmd_d[2].last      = (rest == '0);

      cmd_d[3].kind      = CMD_BUF_WRITE;
      cmd_d[3].buf_sel   = ~active_buf_q;
      cmd_d[3].page      = wp_next;
      cmd_d[3].ofs       = '0;
      cmd_d[3].len       = {{(LenW-SrcW){1'b0}}, rest};
      cmd_d[3].src       = avail[SrcW-1:0];
      cmd_d[3].read_page = rp_next;
      cmd_d[3].last      = 1'b1;

      if (fits) begin
        fill_offset_d = sum[OfsW-1:0];
      end else begin
        write_page_d  = wp_next;
        read_page_d   = rp_next;
        active_buf_d  = ~active_buf_q;
        fill_offset_d = {{(OfsW-SrcW){1'b0}}, rest};
      end
    end else if (take) begin
      cnt_d = cnt_q - QCntW'(1);
      for (int i = 0; i < QDepth-1; i++) begin
        cmd_d[i] = cmd_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_page_q  <= PageW'(1);
      read_page_q   <= PageW'(1);
      fill_offset_q <= '0;
      active_buf_q  <= 1'b0;
      cnt_q         <= '0;
    end else begin
      write_page_q  <= write_page_d;
      read_page_q   <= read_page_d;
      fill_offset_q <= fill_offset_d;
      active_buf_q  <= active_buf_d;
      cnt_q         <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      cmd_q[i] <= cmd_d[i];
    end
  end

  assign out_valid_o   = (cnt_q != '0);
  assign cmd_kind_o    = cmd_q[0].kind;
  assign buffer_sel_o  = cmd_q[0].buf_sel;
  assign page_addr_o   = cmd_q[0].page;
  assign byte_offset_o = cmd_q[0].ofs;
  assign chunk_len_o   = cmd_q[0].len;
  assign src_start_o   = cmd_q[0].src;
  assign read_page_o   = cmd_q[0].read_page;
  assign last_o        = cmd_q[0].last;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("command queue count out of range");

  a_last_at_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (cnt_q == QCntW'(1)))
    else $error("final command word not at queue tail");

  a_accept_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (cnt_q == QCntW'(1) || cnt_q == QCntW'(3) || cnt_q == QCntW'(4)))
    else $error("request produced a bad number of command words");

  a_offset_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, fill_offset_q} < LenW'(PAGE_SIZE))
    else $error("fill offset ran past the page end");
`endif

endmodule

### test/tb_top.sv
// testbench for the circular flash page log writer: random requests checked against a command predictor
module tb_top;
  import fprlw_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int PrintLimit  = 30;
  localparam int TailCycles  = 10;
  localparam int LongRunLen  = 40;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [CountW-1:0] byte_count = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [1:0]        cmd_kind;
  logic              buffer_sel;
  logic [PageW-1:0]  page_addr;
  logic [OfsW-1:0]   byte_offset;
  logic [LenW-1:0]   chunk_len;
  logic [SrcW-1:0]   src_start;
  logic [PageW-1:0]  read_page;
  logic              last;

  flash_page_ring_log_writer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .byte_count_i  (byte_count),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .cmd_kind_o    (cmd_kind),
    .buffer_sel_o  (buffer_sel),
    .page_addr_o   (page_addr),
    .byte_offset_o (byte_offset),
    .chunk_len_o   (chunk_len),
    .src_start_o   (src_start),
    .read_page_o   (read_page),
    .last_o        (last)
  );

  // predicted log state
  logic [PageW-1:0] wr_page  = PageW'(1);
  logic [PageW-1:0] rd_page  = PageW'(1);
  logic [OfsW-1:0]  fill_ofs = '0;
  logic             cur_buf  = 1'b0;

  logic [CountW-1:0] pending_counts[$];
  cmd_t              cmds_due[$];
  cmd_t              head_cmd;

  int  tx_idle_pct = 22;
  int  rx_idle_pct = 72;
  int  gen_ofs = 0;
  int  cycle_count = 0;
  int  mismatches = 0;
  int  requests_taken = 0;
  int  cmds_checked = 0;
  int  ring_wraps = 0;
  int  read_pushes = 0;
  bit  in_took = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [PageW-1:0] next_ring_page(input logic [PageW-1:0] p);
    if (int'(p) + 1 >= NUM_PAGES) begin
      return PageW'(1);
    end
    return p + 1'b1;
  endfunction

  // expands one request into the flash commands it should produce
  task automatic plan_flash_cmds(input logic [CountW-1:0] count);
    int   room;
    int   spill;
    cmd_t c;
    room = (int'(fill_ofs) >= PAGE_SIZE) ? 0 : PAGE_SIZE - int'(fill_ofs);
    if (int'(count) < room) begin
      c = '{CMD_BUF_WRITE, cur_buf, wr_page, fill_ofs, LenW'(count), '0, rd_page, 1'b1};
      cmds_due.push_back(c);
      fill_ofs = fill_ofs + OfsW'(count);
      return;
    end
    spill = int'(count) - room;
    c = '{CMD_BUF_WRITE, cur_buf, wr_page, fill_ofs, LenW'(room), '0, rd_page, 1'b0};
    cmds_due.push_back(c);
    // store still carries the read page from before the advance
    c = '{CMD_STORE, cur_buf, wr_page, '0, '0, '0, rd_page, 1'b0};
    cmds_due.push_back(c);
    fill_ofs = '0;
    if (int'(wr_page) + 1 >= NUM_PAGES) begin
      ring_wraps++;
    end
    wr_page = next_ring_page(wr_page);
    if (rd_page == wr_page) begin
      rd_page = next_ring_page(rd_page);
      read_pushes++;
    end
    cur_buf = ~cur_buf;
    c = '{CMD_META, cur_buf, '0, '0, '0, '0, rd_page, spill == 0};
    cmds_due.push_back(c);
    if (spill > 0) begin
      c = '{CMD_BUF_WRITE, cur_buf, wr_page, '0, LenW'(spill), SrcW'(room), rd_page, 1'b1};
      cmds_due.push_back(c);
      fill_ofs = OfsW'(spill);
    end
  endtask

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= PrintLimit) begin
      $display("error at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report($sformatf("command %0d %s: got %0d, want %0d", cmds_checked, name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("flash_page_ring_log_writer: mismatch");
      $finish;
    end
  end

  // input acceptance, prediction and command checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took = in_valid && !in_stall;
      if (in_took) begin
        plan_flash_cmds(byte_count);
        requests_taken++;
      end
      if (out_valid && !out_stall) begin
        if (cmds_due.size() == 0) begin
          report($sformatf("unexpected command: kind %0d page %0d len %0d",
                           cmd_kind, page_addr, chunk_len));
        end else begin
          head_cmd = cmds_due.pop_front();
          check_field("cmd_kind", cmd_kind, head_cmd.kind);
          check_field("buffer_sel", buffer_sel, head_cmd.buf_sel);
          check_field("page_addr", page_addr, head_cmd.page);
          check_field("byte_offset", byte_offset, head_cmd.ofs);
          check_field("chunk_len", chunk_len, head_cmd.len);
          check_field("src_start", src_start, head_cmd.src);
          check_field("read_page", read_page, head_cmd.read_page);
          check_field("last", last, head_cmd.last);
        end
        cmds_checked++;
      end
    end
  end

  // request driver and command stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      if (!in_valid || in_took) begin
        if (pending_counts.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_valid   <= 1'b1;
          byte_count <= pending_counts.pop_front();
        end else begin
          in_valid   <= 1'b0;
          byte_count <= CountW'($urandom);
        end
      end
    end
  end

  // offset in the page follows the byte total modulo the page size
  task automatic add_request(input int count);
    pending_counts.push_back(CountW'(count));
    gen_ofs = (gen_ofs + count) % PAGE_SIZE;
  endtask

  task automatic queue_requests(input int n, input bit long_run);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 7);
      if (long_run) begin
        add_request($urandom_range(224, 255));
      end else if (pick == 0) begin
        add_request(0);
      end else if (pick == 1) begin
        add_request(255);
      end else if (pick == 2 && gen_ofs > 0) begin
        add_request(PAGE_SIZE - gen_ofs);
      end else if (pick == 3) begin
        add_request($urandom_range(1, 8));
      end else begin
        add_request($urandom_range(0, 255));
      end
    end
  endtask

  task automatic drain_all();
    while (pending_counts.size() > 0 || in_valid || cmds_due.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // zero length, near-full page, exact fills, spill with remainder, full word from offset 0
    add_request(0);
    add_request(255);
    add_request(1);
    add_request(128);
    add_request(128);
    add_request(200);
    add_request(100);
    add_request(0);
    add_request(211);
    add_request(1);
    add_request(255);
    add_request(255);
    add_request(2);
    add_request(170);
    add_request(85);
    add_request(1);
    drain_all();
    queue_requests(120, 1'b0);
    drain_all();
    tx_idle_pct = 72;
    rx_idle_pct = 22;
    queue_requests(120, 1'b0);
    drain_all();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_requests(80, 1'b0);
    // stretch of big words spills into a new page on nearly every request
    queue_requests(LongRunLen, 1'b1);
    queue_requests(20, 1'b0);
    drain_all();
    repeat (TailCycles) @(posedge clk_i);
    $display("run covered %0d requests and %0d flash commands", requests_taken, cmds_checked);
    $display("write page wrapped %0d times, read page pushed ahead %0d times",
             ring_wraps, read_pushes);
    if (mismatches == 0 && cmds_due.size() == 0) begin
      $display("flash_page_ring_log_writer: match");
    end else begin
      $display("%0d mismatches, %0d commands still expected", mismatches, cmds_due.size());
      $display("flash_page_ring_log_writer: mismatch");
    end
    $finish;
  end

endmodule
